// ----- hw/rtl/mcop_pkg.sv -----
`default_nettype none

package mcop_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_KIND         = 3'd0;
    localparam logic [2:0] REG_EXPIRY       = 3'd1;
    localparam logic [2:0] REG_STRIKE       = 3'd2;
    localparam logic [2:0] REG_UPPER_STRIKE = 3'd3;
    localparam logic [2:0] REG_SPOT         = 3'd4;
    localparam logic [2:0] REG_VOLATILITY   = 3'd5;
    localparam logic [2:0] REG_RATE         = 3'd6;
    localparam logic [2:0] REG_PATH_COUNT   = 3'd7;

    // option kinds
    localparam logic [1:0] KIND_CALL   = 2'd0;
    localparam logic [1:0] KIND_PUT    = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;   // pays zero

    // exponential constants
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [3:0]  EXP_TERMS = 4'd13;

    // datapath operations
    localparam logic [4:0] OP_NOP      = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_ZERO     = 5'd2;
    localparam logic [4:0] OP_MUL_VV   = 5'd3;
    localparam logic [4:0] OP_V2       = 5'd4;
    localparam logic [4:0] OP_MUL_VE   = 5'd5;
    localparam logic [4:0] OP_VAR      = 5'd6;
    localparam logic [4:0] OP_SQRT     = 5'd7;
    localparam logic [4:0] OP_SQDONE   = 5'd8;
    localparam logic [4:0] OP_MUL_RE   = 5'd9;
    localparam logic [4:0] OP_XSTART   = 5'd10;
    localparam logic [4:0] OP_EXP_Y    = 5'd11;
    localparam logic [4:0] OP_EXP_KF   = 5'd12;
    localparam logic [4:0] OP_EXP_MT   = 5'd13;
    localparam logic [4:0] OP_EXP_T    = 5'd14;
    localparam logic [4:0] OP_EXP_MTT  = 5'd15;
    localparam logic [4:0] OP_EXP_MR   = 5'd16;
    localparam logic [4:0] OP_EXP_CORR = 5'd17;
    localparam logic [4:0] OP_EXP_MP   = 5'd18;
    localparam logic [4:0] OP_EXP_SH   = 5'd19;
    localparam logic [4:0] OP_MOVED    = 5'd20;
    localparam logic [4:0] OP_MUL_TZ   = 5'd21;
    localparam logic [4:0] OP_XTERM    = 5'd22;
    localparam logic [4:0] OP_PAY      = 5'd23;
    localparam logic [4:0] OP_DINIT    = 5'd24;
    localparam logic [4:0] OP_DIV      = 5'd25;
    localparam logic [4:0] OP_MEAN     = 5'd26;
    localparam logic [4:0] OP_XDISC    = 5'd27;
    localparam logic [4:0] OP_EMIT     = 5'd28;

    typedef struct packed {
        logic [4:0] op;
        logic [3:0] n;     // taylor term index
    } mcop_cmd_t;

    typedef struct packed {
        logic pc_zero;
        logic run_start;
        logic run_done;
        logic out_busy;
    } mcop_status_t;

    // floor(2^32 / n) for the taylor divisions
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        case (n)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            4'd13:   r = 33'd330382099;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mcop_ctrl.sv -----
`default_nettype none

module mcop_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire mcop_pkg::mcop_status_t status,
    output mcop_pkg::mcop_cmd_t        cmd,
    output logic                       in_ready
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ZERO   = 5'd1;
    localparam logic [4:0] ST_MVV    = 5'd2;
    localparam logic [4:0] ST_V2     = 5'd3;
    localparam logic [4:0] ST_MVE    = 5'd4;
    localparam logic [4:0] ST_VAR    = 5'd5;
    localparam logic [4:0] ST_SQRT   = 5'd6;
    localparam logic [4:0] ST_SQDONE = 5'd7;
    localparam logic [4:0] ST_MRE    = 5'd8;
    localparam logic [4:0] ST_XSTART = 5'd9;
    localparam logic [4:0] ST_EY     = 5'd10;
    localparam logic [4:0] ST_EKF    = 5'd11;
    localparam logic [4:0] ST_EMT    = 5'd12;
    localparam logic [4:0] ST_ET     = 5'd13;
    localparam logic [4:0] ST_EMTT   = 5'd14;
    localparam logic [4:0] ST_EMR    = 5'd15;
    localparam logic [4:0] ST_ECORR  = 5'd16;
    localparam logic [4:0] ST_EMP    = 5'd17;
    localparam logic [4:0] ST_ESH    = 5'd18;
    localparam logic [4:0] ST_MOVED  = 5'd19;
    localparam logic [4:0] ST_MTZ    = 5'd20;
    localparam logic [4:0] ST_XTERM  = 5'd21;
    localparam logic [4:0] ST_PAY    = 5'd22;
    localparam logic [4:0] ST_CHECK  = 5'd23;
    localparam logic [4:0] ST_DINIT  = 5'd24;
    localparam logic [4:0] ST_DIV    = 5'd25;
    localparam logic [4:0] ST_MEAN   = 5'd26;
    localparam logic [4:0] ST_MRE2   = 5'd27;
    localparam logic [4:0] ST_XDISC  = 5'd28;
    localparam logic [4:0] ST_EMIT   = 5'd29;

    localparam logic [1:0] RET_MOVED = 2'd0;
    localparam logic [1:0] RET_TERM  = 2'd1;
    localparam logic [1:0] RET_DISC  = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [4:0] op;

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.op   = op;
    assign cmd.n    = cnt_reg[3:0];

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        op         = mcop_pkg::OP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op = mcop_pkg::OP_LOAD;
                    if (status.pc_zero)
                        state_next = ST_ZERO;
                    else if (status.run_start)
                        state_next = ST_MVV;
                    else
                        state_next = ST_MTZ;
                end
            end
            ST_ZERO:
            begin
                if (!status.out_busy)
                begin
                    op         = mcop_pkg::OP_ZERO;
                    state_next = ST_IDLE;
                end
            end
            ST_MVV:
            begin
                op         = mcop_pkg::OP_MUL_VV;
                state_next = ST_V2;
            end
            ST_V2:
            begin
                op         = mcop_pkg::OP_V2;
                state_next = ST_MVE;
            end
            ST_MVE:
            begin
                op         = mcop_pkg::OP_MUL_VE;
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                op         = mcop_pkg::OP_VAR;
                cnt_next   = 7'd0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                op       = mcop_pkg::OP_SQRT;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31)
                    state_next = ST_SQDONE;
            end
            ST_SQDONE:
            begin
                op         = mcop_pkg::OP_SQDONE;
                state_next = ST_MRE;
            end
            ST_MRE:
            begin
                op         = mcop_pkg::OP_MUL_RE;
                state_next = ST_XSTART;
            end
            ST_XSTART:
            begin
                op         = mcop_pkg::OP_XSTART;
                ret_next   = RET_MOVED;
                state_next = ST_EY;
            end
            ST_EY:
            begin
                op         = mcop_pkg::OP_EXP_Y;
                state_next = ST_EKF;
            end
            ST_EKF:
            begin
                op         = mcop_pkg::OP_EXP_KF;
                state_next = ST_EMT;
            end
            ST_EMT:
            begin
                op         = mcop_pkg::OP_EXP_MT;
                state_next = ST_ET;
            end
            ST_ET:
            begin
                op         = mcop_pkg::OP_EXP_T;
                cnt_next   = 7'd1;
                state_next = ST_EMTT;
            end
            ST_EMTT:
            begin
                op         = mcop_pkg::OP_EXP_MTT;
                state_next = ST_EMR;
            end
            ST_EMR:
            begin
                op         = mcop_pkg::OP_EXP_MR;
                state_next = ST_ECORR;
            end
            ST_ECORR:
            begin
                op = mcop_pkg::OP_EXP_CORR;
                if (cnt_reg[3:0] == mcop_pkg::EXP_TERMS)
                    state_next = ST_EMP;
                else
                begin
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = ST_EMTT;
                end
            end
            ST_EMP:
            begin
                op         = mcop_pkg::OP_EXP_MP;
                state_next = ST_ESH;
            end
            ST_ESH:
            begin
                op = mcop_pkg::OP_EXP_SH;
                case (ret_reg)
                    RET_MOVED: state_next = ST_MOVED;
                    RET_TERM:  state_next = ST_PAY;
                    default:   state_next = ST_EMIT;
                endcase
            end
            ST_MOVED:
            begin
                op         = mcop_pkg::OP_MOVED;
                state_next = ST_MTZ;
            end
            ST_MTZ:
            begin
                op         = mcop_pkg::OP_MUL_TZ;
                state_next = ST_XTERM;
            end
            ST_XTERM:
            begin
                op         = mcop_pkg::OP_XTERM;
                ret_next   = RET_TERM;
                state_next = ST_EY;
            end
            ST_PAY:
            begin
                op         = mcop_pkg::OP_PAY;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.run_done)
                    state_next = ST_DINIT;
                else
                    state_next = ST_IDLE;
            end
            ST_DINIT:
            begin
                op         = mcop_pkg::OP_DINIT;
                cnt_next   = 7'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                op       = mcop_pkg::OP_DIV;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                    state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                op         = mcop_pkg::OP_MEAN;
                state_next = ST_MRE2;
            end
            ST_MRE2:
            begin
                op         = mcop_pkg::OP_MUL_RE;
                state_next = ST_XDISC;
            end
            ST_XDISC:
            begin
                op         = mcop_pkg::OP_XDISC;
                ret_next   = RET_DISC;
                state_next = ST_EY;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    op         = mcop_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_MOVED;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mcop_dp.sv -----
`default_nettype none

module mcop_dp #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mcop_pkg::mcop_cmd_t   cmd,
    input  wire logic [23:0]           sample,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  out_ready,
    output mcop_pkg::mcop_status_t     status,
    output logic                       out_valid,
    output logic [31:0]                out_price,
    output logic                       out_sat
);

    localparam int F  = FRACTION_BITS;
    localparam int XW = F + 8;
    localparam logic signed [63:0] LIM    = 64'sd64 <<< F;
    localparam logic [31:0]        MAX32  = 32'hFFFF_FFFF;
    localparam logic [31:0]        ONE_FX = 32'd1 << F;

    // configuration
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] expiry_reg, expiry_next, strike_reg, strike_next;
    logic [31:0] upper_reg, upper_next, spot_reg, spot_next;
    logic [31:0] vol_reg, vol_next, rate_reg, rate_next, pcount_reg, pcount_next;
    // run state
    logic [63:0] sum_reg, sum_next;
    logic [31:0] done_reg, done_next, moved_reg, moved_next, rootv_reg, rootv_next;
    logic        satseen_reg, satseen_next, out_valid_reg, out_valid_next;
    // working registers
    logic signed [23:0] z_reg, z_next;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [63:0] x_reg, x_next;
    logic signed [7:0]  k_reg, k_next;
    logic [31:0] wa_reg, wa_next, val_reg, val_next, m_reg, m_next, res_reg, res_next;
    logic [29:0] t_reg, t_next, a_reg, a_next;
    logic [30:0] term_reg, term_next;
    logic [63:0] sh_reg, sh_next, root_reg, root_next;
    logic [34:0] rem_reg, rem_next;
    logic        satw_reg, satw_next;
    logic [31:0] out_price_reg, out_price_next;
    logic        out_sat_reg, out_sat_next;

    // combinational helpers
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic               mul_en;
    logic signed [63:0] xc;
    logic signed [XW-1:0] xc_n;
    logic signed [67:0] prod_shf, prod_sh20;
    logic signed [63:0] rte;
    logic [63:0] p;
    logic signed [7:0] kd;
    logic [63:0] r64;
    logic        esat;
    logic [31:0] eres;
    logic [29:0] q0;
    logic [33:0] qn;
    logic [29:0] rr;
    logic [30:0] q;
    logic [31:0] pay;
    logic [34:0] sq_rem, sq_trial;
    logic [32:0] dv_rem;

    assign status.pc_zero   = (pcount_reg == 32'd0);
    assign status.run_start = (done_reg == 32'd0);
    assign status.run_done  = (done_reg >= pcount_reg);
    assign status.out_busy  = out_valid_reg & ~out_ready;
    assign out_valid = out_valid_reg;
    assign out_price = out_price_reg;
    assign out_sat   = out_sat_reg;

    // clamp the exponent argument to +-64
    always_comb
    begin
        if (x_reg > LIM)
            xc = LIM;
        else if (x_reg < -LIM)
            xc = -LIM;
        else
            xc = x_reg;
        xc_n = xc[XW-1:0];
    end

    assign prod_shf  = prod_reg >>> F;
    assign prod_sh20 = prod_reg >>> 20;
    assign rte       = prod_shf[63:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            mcop_pkg::OP_MUL_VV:
            begin
                mul_a = {2'b0, vol_reg};
                mul_b = {2'b0, vol_reg};
            end
            mcop_pkg::OP_MUL_VE:
            begin
                mul_a = {2'b0, wa_reg};
                mul_b = {2'b0, expiry_reg};
            end
            mcop_pkg::OP_MUL_RE:
            begin
                mul_a = {{2{rate_reg[31]}}, rate_reg};
                mul_b = {2'b0, expiry_reg};
            end
            mcop_pkg::OP_MUL_TZ:
            begin
                mul_a = {2'b0, rootv_reg};
                mul_b = 34'(z_reg);
            end
            mcop_pkg::OP_EXP_Y:
            begin
                mul_a = 34'(xc_n);
                mul_b = {3'b0, mcop_pkg::LOG2E_Q30};
            end
            mcop_pkg::OP_EXP_MT:
            begin
                mul_a = {4'b0, t_reg};
                mul_b = {4'b0, mcop_pkg::LN2_Q30};
            end
            mcop_pkg::OP_EXP_MTT:
            begin
                mul_a = {3'b0, term_reg};
                mul_b = {4'b0, t_reg};
            end
            mcop_pkg::OP_EXP_MR:
            begin
                mul_a = {4'b0, prod_reg[59:30]};
                mul_b = {1'b0, mcop_pkg::recip(cmd.n)};
            end
            mcop_pkg::OP_EXP_MP:
            begin
                mul_a = {2'b0, val_reg};
                mul_b = {2'b0, m_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // final power-of-two scaling of value * mantissa
    always_comb
    begin
        p    = {1'b0, prod_reg[62:0]};
        kd   = 8'sd0;
        r64  = 64'd0;
        esat = 1'b0;
        if (k_reg <= 8'sd30)
        begin
            kd = 8'sd30 - k_reg;
            if (kd[6])
                r64 = 64'd0;
            else
                r64 = p >> kd[5:0];
            esat = |r64[63:32];
        end
        else
        begin
            kd = k_reg - 8'sd30;
            if (kd[5])
                esat = |p;
            else
                esat = |(p >> (6'd32 - kd[5:0]));
            r64 = p << kd[5:0];
        end
        eres = esat ? MAX32 : r64[31:0];
    end

    // taylor division correction, payoff, root and divider steps
    always_comb
    begin
        q0       = prod_reg[61:32];
        qn       = q0 * cmd.n;
        rr       = a_reg - qn[29:0];
        q        = {1'b0, q0} + ((rr >= {26'b0, cmd.n}) ? 31'd1 : 31'd0);
        sq_rem   = {rem_reg[32:0], sh_reg[63:62]};
        sq_trial = {1'b0, root_reg[31:0], 2'b01};
        dv_rem   = {rem_reg[31:0], sh_reg[63]};
        case (kind_reg)
            mcop_pkg::KIND_CALL:
                pay = (res_reg > strike_reg) ? res_reg - strike_reg : 32'd0;
            mcop_pkg::KIND_PUT:
                pay = (strike_reg > res_reg) ? strike_reg - res_reg : 32'd0;
            mcop_pkg::KIND_DOUBLE:
                pay = (strike_reg < res_reg && res_reg < upper_reg) ? ONE_FX : 32'd0;
            default:
                pay = 32'd0;
        endcase
    end

    always_comb
    begin
        kind_next      = kind_reg;
        expiry_next    = expiry_reg;
        strike_next    = strike_reg;
        upper_next     = upper_reg;
        spot_next      = spot_reg;
        vol_next       = vol_reg;
        rate_next      = rate_reg;
        pcount_next    = pcount_reg;
        sum_next       = sum_reg;
        done_next      = done_reg;
        moved_next     = moved_reg;
        rootv_next     = rootv_reg;
        satseen_next   = satseen_reg;
        z_next         = z_reg;
        prod_next      = mul_en ? mul_p : prod_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        wa_next        = wa_reg;
        val_next       = val_reg;
        m_next         = m_reg;
        res_next       = res_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        term_next      = term_reg;
        sh_next        = sh_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        satw_next      = satw_reg;
        out_price_next = out_price_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                mcop_pkg::REG_KIND:         kind_next   = cfg_data[1:0];
                mcop_pkg::REG_EXPIRY:       expiry_next = cfg_data;
                mcop_pkg::REG_STRIKE:       strike_next = cfg_data;
                mcop_pkg::REG_UPPER_STRIKE: upper_next  = cfg_data;
                mcop_pkg::REG_SPOT:         spot_next   = cfg_data;
                mcop_pkg::REG_VOLATILITY:   vol_next    = cfg_data;
                mcop_pkg::REG_RATE:         rate_next   = cfg_data;
                mcop_pkg::REG_PATH_COUNT:   pcount_next = cfg_data;
                default:                    kind_next   = kind_reg;
            endcase
        end

        case (cmd.op)
            mcop_pkg::OP_LOAD:
            begin
                z_next    = sample;
                satw_next = satseen_reg;
            end
            mcop_pkg::OP_ZERO:
            begin
                out_price_next = 32'd0;
                out_sat_next   = 1'b1;
                out_valid_next = 1'b1;
                sum_next       = 64'd0;
                done_next      = 32'd0;
                satseen_next   = 1'b0;
            end
            mcop_pkg::OP_V2, mcop_pkg::OP_VAR:
            begin
                if (|prod_reg[63:F+32])
                begin
                    wa_next   = MAX32;
                    satw_next = 1'b1;
                end
                else
                    wa_next = prod_reg[F +: 32];
                if (cmd.op == mcop_pkg::OP_VAR)
                begin
                    sh_next   = {32'd0, wa_next} << F;
                    rem_next  = 35'd0;
                    root_next = 64'd0;
                end
            end
            mcop_pkg::OP_SQRT:
            begin
                sh_next = {sh_reg[61:0], 2'b00};
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = sq_rem - sq_trial;
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[62:0], 1'b0};
                end
            end
            mcop_pkg::OP_SQDONE:
                rootv_next = root_reg[31:0];
            mcop_pkg::OP_XSTART:
            begin
                x_next   = rte - $signed({33'd0, wa_reg[31:1]});
                val_next = spot_reg;
            end
            mcop_pkg::OP_EXP_KF:
            begin
                k_next = prod_reg[F+37:F+30];
                t_next = prod_reg[F+29:F];
            end
            mcop_pkg::OP_EXP_T:
            begin
                t_next    = prod_reg[59:30];
                term_next = 31'd1 << 30;
                m_next    = 32'd1 << 30;
            end
            mcop_pkg::OP_EXP_MR:
                a_next = prod_reg[59:30];
            mcop_pkg::OP_EXP_CORR:
            begin
                term_next = q;
                m_next    = m_reg + {1'b0, q};
            end
            mcop_pkg::OP_EXP_SH:
            begin
                res_next  = eres;
                satw_next = satw_reg | esat;
            end
            mcop_pkg::OP_MOVED:
                moved_next = res_reg;
            mcop_pkg::OP_XTERM:
            begin
                x_next   = prod_sh20[63:0];
                val_next = moved_reg;
            end
            mcop_pkg::OP_PAY:
            begin
                sum_next     = sum_reg + {32'd0, pay};
                done_next    = done_reg + 32'd1;
                satseen_next = satw_reg;
            end
            mcop_pkg::OP_DINIT:
            begin
                sh_next   = sum_reg;
                rem_next  = 35'd0;
                root_next = 64'd0;
            end
            mcop_pkg::OP_DIV:
            begin
                sh_next = {sh_reg[62:0], 1'b0};
                if (dv_rem >= {1'b0, pcount_reg})
                begin
                    rem_next  = {2'b0, dv_rem - {1'b0, pcount_reg}};
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next  = {2'b0, dv_rem};
                    root_next = {root_reg[62:0], 1'b0};
                end
            end
            mcop_pkg::OP_MEAN:
            begin
                if (|root_reg[63:32])
                begin
                    val_next  = MAX32;
                    satw_next = 1'b1;
                end
                else
                    val_next = root_reg[31:0];
            end
            mcop_pkg::OP_XDISC:
                x_next = -rte;
            mcop_pkg::OP_EMIT:
            begin
                out_price_next = res_reg;
                out_sat_next   = satw_reg;
                out_valid_next = 1'b1;
                sum_next       = 64'd0;
                done_next      = 32'd0;
                satseen_next   = 1'b0;
            end
            default:
            begin
                z_next = z_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= mcop_pkg::KIND_CALL;
            expiry_reg    <= ONE_FX;
            strike_reg    <= 32'd0;
            upper_reg     <= 32'd0;
            spot_reg      <= 32'd0;
            vol_reg       <= 32'd0;
            rate_reg      <= 32'd0;
            pcount_reg    <= 32'd1;
            sum_reg       <= 64'd0;
            done_reg      <= 32'd0;
            moved_reg     <= 32'd0;
            rootv_reg     <= 32'd0;
            satseen_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            expiry_reg    <= expiry_next;
            strike_reg    <= strike_next;
            upper_reg     <= upper_next;
            spot_reg      <= spot_next;
            vol_reg       <= vol_next;
            rate_reg      <= rate_next;
            pcount_reg    <= pcount_next;
            sum_reg       <= sum_next;
            done_reg      <= done_next;
            moved_reg     <= moved_next;
            rootv_reg     <= rootv_next;
            satseen_reg   <= satseen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        prod_reg      <= prod_next;
        x_reg         <= x_next;
        k_reg         <= k_next;
        wa_reg        <= wa_next;
        val_reg       <= val_next;
        m_reg         <= m_next;
        res_reg       <= res_next;
        t_reg         <= t_next;
        a_reg         <= a_next;
        term_reg      <= term_next;
        sh_reg        <= sh_next;
        root_reg      <= root_next;
        rem_reg       <= rem_next;
        satw_reg      <= satw_next;
        out_price_reg <= out_price_next;
        out_sat_reg   <= out_sat_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/monte_carlo_option_pricer_core.sv -----
// each sample on a running path takes one exponential
// first sample of a run adds a 32-step root and an exponential for the moved spot
// last sample adds a 64-step divide and the discount exponential before the price
// throughput: one sample at a time, set by the shared 34x34 multiplier and the 13-term series
// zero path count: the result is a zero price with the saturated flag, sent once the output is free
// reset: asynchronous active low, registers to their defaults, run state cleared
`default_nettype none

module monte_carlo_option_pricer_core #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] gaussian_sample
    // price stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] price
    output logic             m_axis_tuser,   // [0] saturated
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    mcop_pkg::mcop_cmd_t    cmd;
    mcop_pkg::mcop_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accepts a sample when idle and walks the arithmetic steps
    mcop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    // datapath: registers, shared multiplier, root and divide steps, output register
    mcop_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_price (m_axis_tdata),
        .out_sat   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mcop_chk.sv -----
`default_nettype none

module mcop_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [23:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [2:0]  cfg_index,
    input wire logic [31:0] cfg_data
);

    // a stalled price stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("price dropped while stalled");

    // a stalled price keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("price changed while stalled");

    // one sample in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken while busy");

    // no price appears in the cycle right after a sample transaction
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("price appeared too early");

endmodule

bind monte_carlo_option_pricer_core mcop_chk u_mcop_chk (.*);

`default_nettype wire

// ----- sim/monte_carlo_option_pricer_core_tb.sv -----
`default_nettype none

module monte_carlo_option_pricer_core_tb;

    // fixed-point layout of the default build
    localparam int          FB        = 16;
    localparam longint      LOG2E     = 64'sd1549082005;
    localparam logic [63:0] LN2       = 64'd744261118;
    localparam logic [63:0] MAX32     = 64'hFFFF_FFFF;
    localparam logic [31:0] ONE       = 32'h0001_0000;
    // quiet time after the queue of prices runs dry
    localparam int          SETTLE    = 400;
    localparam int          N_RANDOM  = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    monte_carlo_option_pricer_core #(.FRACTION_BITS(FB)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // -------------------------------------------------------------------------
    // pricer mirror: register copies and run state
    // -------------------------------------------------------------------------
    logic [1:0]  opt_kind;
    logic [31:0] opt_expiry, opt_strike, opt_upper, opt_spot, opt_vol, opt_rate, opt_paths;
    logic [63:0] run_sum;
    logic [31:0] run_count, run_moved_spot, run_root_var;
    bit          run_sat;
    bit          step_sat;     // saturation seen by the current exponential

    typedef struct packed {
        logic [31:0] price;
        logic        saturated;
    } price_t;

    price_t expected_prices[$];

    int errors    = 0;
    int n_samples = 0;
    int n_prices  = 0;
    int n_writes  = 0;
    int n_sat     = 0;
    bit no_idle   = 1'b0;

    // a directed row may carry its price typed in by hand
    logic        pin_valid = 1'b0;
    price_t      pin_price = '0;

    task automatic mirror_reset();
        opt_kind = mcop_pkg::KIND_CALL;
        opt_expiry = ONE;
        opt_strike = '0; opt_upper = '0; opt_spot = '0; opt_vol = '0; opt_rate = '0;
        opt_paths = 32'd1;
        run_sum = '0; run_count = '0; run_moved_spot = '0; run_root_var = '0;
        run_sat = 1'b0;
    endtask

    task automatic mirror_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            mcop_pkg::REG_KIND:         opt_kind   = val[1:0];
            mcop_pkg::REG_EXPIRY:       opt_expiry = val;
            mcop_pkg::REG_STRIKE:       opt_strike = val;
            mcop_pkg::REG_UPPER_STRIKE: opt_upper  = val;
            mcop_pkg::REG_SPOT:         opt_spot   = val;
            mcop_pkg::REG_VOLATILITY:   opt_vol    = val;
            mcop_pkg::REG_RATE:         opt_rate   = val;
            default:                    opt_paths  = val;
        endcase
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bit_pos, rem;
        res = '0;
        bit_pos = 64'd1 << 62;
        rem = n;
        while (bit_pos > rem)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (rem >= res + bit_pos)
            begin
                rem = rem - (res + bit_pos);
                res = (res >> 1) + bit_pos;
            end
            else
                res = res >> 1;
            bit_pos = bit_pos >> 2;
        end
        return res;
    endfunction

    // value * e^x with x signed Q.F, 32-bit saturation recorded in step_sat
    function automatic logic [63:0] scale_by_exp(input logic [63:0] value, input longint x);
        longint      lim, xc, y, k, sh;
        logic [63:0] frac, t, term, m, p, r;
        lim = longint'(64) << FB;
        xc = x;
        if (xc > lim) xc = lim;
        if (xc < -lim) xc = -lim;
        y = xc * LOG2E;
        k = y >>> (FB + 30);
        frac = ($unsigned(y) & ((64'd1 << (FB + 30)) - 1)) >> FB;
        t = (frac * LN2) >> 30;
        m = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 13; n++)
        begin
            term = ((term * t) >> 30) / n;
            m = m + term;
        end
        p = value * m;
        if (k <= 30)
        begin
            sh = 30 - k;
            if (sh >= 64)
                return '0;
            r = p >> sh;
        end
        else
        begin
            sh = k - 30;
            if (sh >= 32 ? p != 0 : p > (MAX32 >> sh))
            begin
                step_sat = 1'b1;
                return MAX32;
            end
            r = p << sh;
        end
        if (r > MAX32)
        begin
            step_sat = 1'b1;
            return MAX32;
        end
        return r;
    endfunction

    function automatic longint discount_exponent();
        longint rs;
        rs = longint'($signed(opt_rate));
        return (rs * longint'({32'd0, opt_expiry})) >>> FB;
    endfunction

    // one gaussian draw through the mirror; returns 1 when a price falls out
    function automatic bit price_from_draw(input logic [23:0] z, output price_t res);
        logic [63:0] v2, variance, s, pay, mean, pr;
        longint      zs;
        res = '0;
        if (opt_paths == 0)
        begin
            run_sum = '0; run_count = '0; run_sat = 1'b0;
            res.saturated = 1'b1;
            return 1'b1;
        end
        if (run_count == 0)
        begin
            // run start: derive moved spot and root variance
            step_sat = 1'b0;
            v2 = ({32'd0, opt_vol} * {32'd0, opt_vol}) >> FB;
            if (v2 > MAX32) begin v2 = MAX32; step_sat = 1'b1; end
            variance = (v2 * {32'd0, opt_expiry}) >> FB;
            if (variance > MAX32) begin variance = MAX32; step_sat = 1'b1; end
            run_root_var = 32'(int_sqrt(variance << FB));
            run_moved_spot = 32'(scale_by_exp({32'd0, opt_spot},
                                 discount_exponent() - longint'(variance >> 1)));
            run_sum = '0;
            run_sat = step_sat;
        end
        step_sat = run_sat;
        zs = longint'($signed(z));
        s = scale_by_exp({32'd0, run_moved_spot},
                         (longint'({32'd0, run_root_var}) * zs) >>> 20);
        case (opt_kind)
            mcop_pkg::KIND_CALL:   pay = (s > opt_strike) ? s - opt_strike : '0;
            mcop_pkg::KIND_PUT:    pay = (opt_strike > s) ? opt_strike - s : '0;
            mcop_pkg::KIND_DOUBLE:
                pay = (opt_strike < s && s < opt_upper) ? {32'd0, ONE} : '0;
            default:               pay = '0;
        endcase
        run_sum = run_sum + pay;
        run_count = run_count + 1;
        run_sat = step_sat;
        if (run_count >= opt_paths)
        begin
            mean = run_sum / opt_paths;
            if (mean > MAX32) begin mean = MAX32; step_sat = 1'b1; end
            pr = scale_by_exp(mean, -discount_exponent());
            res.price = pr[31:0];
            res.saturated = step_sat;
            run_sum = '0; run_count = '0; run_sat = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // -------------------------------------------------------------------------
    // monitor: every transaction is sampled at the rising edge
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin
        price_t pred, got, want;
        bit     has_price;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                mirror_write(cfg_index, cfg_data);
                n_writes++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_samples++;
                has_price = price_from_draw(s_axis_tdata, pred);
                if (pin_valid)
                begin
                    // hand-typed price of a directed row stands in for the mirror
                    if (!has_price)
                    begin
                        $error("directed row expects a price, mirror gives none");
                        errors++;
                    end
                    expected_prices.push_back(pin_price);
                end
                else if (has_price)
                    expected_prices.push_back(pred);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.price = m_axis_tdata;
                got.saturated = m_axis_tuser;
                n_prices++;
                if (got.saturated) n_sat++;
                if (expected_prices.size() == 0)
                begin
                    $error("unexpected price transaction: price %h saturated %0d",
                           got.price, got.saturated);
                    errors++;
                end
                else
                begin
                    want = expected_prices.pop_front();
                    if (got.price !== want.price)
                    begin
                        $error("price: expected %h actual %h", want.price, got.price);
                        errors++;
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d actual %0d",
                               want.saturated, got.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // price side: ready toggles in random bursts
    // -------------------------------------------------------------------------
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!no_idle && $urandom_range(0, 1))
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // -------------------------------------------------------------------------
    // drivers
    // -------------------------------------------------------------------------
    task automatic send_draw(input logic [23:0] z, input bit typed, input price_t typed_price);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z;
        pin_valid     <= typed;
        pin_price     <= typed_price;
        do @(posedge clk); while (!s_axis_tready);
        // hold valid across back-to-back transactions, drop it only for a gap
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // register writes only with the block idle: prices all back, then a quiet spell
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_prices.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = $urandom;
            default:
            begin
                case (idx)
                    mcop_pkg::REG_KIND:       v = $urandom_range(0, 3);
                    mcop_pkg::REG_EXPIRY:     v = $urandom_range(0, 5 * 65536);
                    mcop_pkg::REG_VOLATILITY: v = $urandom_range(0, 65536);
                    mcop_pkg::REG_RATE:       v = $urandom_range(0, 13108) - 6554;
                    default:                  v = $urandom_range(50 * 65536, 150 * 65536);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_path_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom_range(16, 24);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // directed rows: reset state, zero path count, each kind, mid-run path cut
    // -------------------------------------------------------------------------
    typedef enum logic { ROW_CFG, ROW_DRAW } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] val;       // register value or draw in the low 24 bits
        bit          typed;
        price_t      want;
    } row_t;

    localparam int N_ROWS = 25;
    row_t rows[N_ROWS] = '{
        // straight out of reset: spot zero so the call pays nothing
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0000, 1'b1, '{32'h0, 1'b0}},
        // zero path count gives zero and the flag for every draw
        '{ROW_CFG,  mcop_pkg::REG_PATH_COUNT,   32'd0,         1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h007F_FFFF, 1'b1, '{32'h0, 1'b1}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0080_0000, 1'b1, '{32'h0, 1'b1}},
        // at the money call, three paths
        '{ROW_CFG,  mcop_pkg::REG_SPOT,         32'h0064_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_VOLATILITY,   32'd13107,     1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_RATE,         32'd3277,      1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_STRIKE,       32'h0064_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_UPPER_STRIKE, 32'h0078_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_PATH_COUNT,   32'd3,         1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h007F_FFFF, 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0080_0000, 1'b0, '{32'h0, 1'b0}},
        // put, run of five cut down to two after three draws
        '{ROW_CFG,  mcop_pkg::REG_KIND,   32'(mcop_pkg::KIND_PUT), 1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_PATH_COUNT,   32'd5,         1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0010_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h00F0_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0001, 1'b0, '{32'h0, 1'b0}},
        '{ROW_CFG,  mcop_pkg::REG_PATH_COUNT,   32'd2,         1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
        // double digital between the strikes
        '{ROW_CFG,  mcop_pkg::REG_KIND, 32'(mcop_pkg::KIND_DOUBLE), 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0008_0000, 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0000, 1'b0, '{32'h0, 1'b0}},
        // the fourth kind pays nothing
        '{ROW_CFG,  mcop_pkg::REG_KIND,  32'(mcop_pkg::KIND_NONE), 1'b0, '{32'h0, 1'b0}},
        '{ROW_DRAW, mcop_pkg::REG_KIND,         32'h0000_0000, 1'b0, '{32'h0, 1'b0}}
    };

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial
    begin
        int  sent;
        bit  last_was_draw;
        logic [23:0] z;
        mirror_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last_was_draw = 1'b0;
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                if (last_was_draw)
                    wait_idle();
                write_reg(rows[i].idx, rows[i].val);
                last_was_draw = 1'b0;
            end
            else
            begin
                send_draw(rows[i].val[23:0], rows[i].typed, rows[i].want);
                last_was_draw = 1'b1;
            end
        end

        // random phases: new settings, then a burst of draws; runs may span phases
        sent = 0;
        while (sent < N_RANDOM)
        begin
            wait_idle();
            for (int r = 0; r < 8; r++)
                if ($urandom_range(0, 2) == 0)
                    write_reg(3'(r), (3'(r) == mcop_pkg::REG_PATH_COUNT)
                                     ? pick_path_count() : pick_reg_value(3'(r)));
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 1))
                    z = 24'($urandom);
                else
                    z = 24'($urandom_range(0, 24'h40_0000)) - 24'h20_0000;
                send_draw(z, 1'b0, '0);
                sent++;
                if (sent > (N_RANDOM * 3) / 4)
                    no_idle = 1'b1;
            end
        end

        wait_idle();
        $display("run covered %0d draws, %0d prices (%0d saturated), %0d register writes",
                 n_samples, n_prices, n_sat, n_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #80_000_000;
        $display("timeout with %0d prices outstanding", expected_prices.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ----- monte_carlo_option_pricer_core.f -----
hw/rtl/mcop_pkg.sv
hw/rtl/mcop_ctrl.sv
hw/rtl/mcop_dp.sv
hw/rtl/monte_carlo_option_pricer_core.sv
hw/rtl/mcop_chk.sv
sim/monte_carlo_option_pricer_core_tb.sv
